>>> sv/cst_pkg.sv
`default_nettype none

package cst_pkg;

   // Width of a slot index carried to the cells; covers the largest capacity (256 slots)
   localparam int IDX_W = 8;

   // Field widths of the two channels
   localparam int MODE_W  = 4;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 6;
   localparam int CURSOR_W = 5;
   localparam int ERR_W   = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_START          = 4'd0,
      MODE_END            = 4'd1,
      MODE_LAST           = 4'd2,
      MODE_ADVANCE        = 4'd3,
      MODE_RETREAT        = 4'd4,
      MODE_INSERT         = 4'd5,
      MODE_INSERT_FRONT   = 4'd6,
      MODE_ATTACH         = 4'd7,
      MODE_ATTACH_BACK    = 4'd8,
      MODE_REMOVE_CURRENT = 4'd9,
      MODE_REMOVE_FRONT   = 4'd10,
      MODE_READ           = 4'd11
   } mode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE    = 2'd0,
      ERR_FULL    = 2'd1,
      ERR_NO_ITEM = 2'd2
   } err_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_LOAD = 1'b1
   } state_type;

   // Broadcast from the control unit to every cell of the row
   typedef struct packed {
      logic             shift_up;    // open a gap at slot 'at'
      logic             write;       // store the new word at slot 'at'
      logic             shift_down;  // close slot 'at'
      logic [IDX_W-1:0] at;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> sv/cst_ifs.sv
`default_nettype none

interface cst_req_if;
   logic                         valid;
   logic                         ready;
   logic [cst_pkg::MODE_W-1:0]   mode;
   logic [cst_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cst_pkg::VALUE_W-1:0]   current_value;
   logic                          current_valid;
   logic [cst_pkg::COUNT_W-1:0]   count;
   logic [cst_pkg::CURSOR_W-1:0]  cursor;
   logic [cst_pkg::ERR_W-1:0]     error;

   modport source (output valid, output current_value, output current_valid,
                   output count, output cursor, output error, input ready);
   modport sink   (input valid, input current_value, input current_valid,
                   input count, input cursor, input error, output ready);
endinterface

`default_nettype wire

>>> sv/cst_cell.sv
`default_nettype none

module cst_cell #(
   parameter int INDEX      = 0,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire cst_pkg::cell_ctrl_type ctl,
   input  wire logic [WORD_WIDTH-1:0] word,
   input  wire logic [WORD_WIDTH-1:0] left_word,
   input  wire logic [WORD_WIDTH-1:0] right_word,
   output logic      [WORD_WIDTH-1:0] entry
);

   localparam logic [cst_pkg::IDX_W-1:0] MY_IDX = cst_pkg::IDX_W'(INDEX);

   logic [WORD_WIDTH-1:0] entry_ff;
   logic [WORD_WIDTH-1:0] entry_in;

   // Pick from the left neighbor, the new word, the right neighbor, or hold
   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift_up && (MY_IDX > ctl.at)) begin
         entry_in = left_word;
      end else if (ctl.write && (MY_IDX == ctl.at)) begin
         entry_in = word;
      end else if (ctl.shift_down && (MY_IDX >= ctl.at)) begin
         entry_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

>>> sv/cst_ctrl.sv
`default_nettype none

module cst_ctrl #(
   parameter int CAPACITY_ENTRIES = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [cst_pkg::MODE_W-1:0]       mode,
   output cst_pkg::cell_ctrl_type                ctl,
   output logic [$clog2(CAPACITY_ENTRIES+1)-1:0] occ,
   output logic [$clog2(CAPACITY_ENTRIES)-1:0]   pos,
   output cst_pkg::err_type                      err
);

   localparam int OCC_W = $clog2(CAPACITY_ENTRIES + 1);
   localparam int POS_W = $clog2(CAPACITY_ENTRIES);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY_ENTRIES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(CAPACITY_ENTRIES - 1);

   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   cst_pkg::err_type       err_ff, err_in;
   cst_pkg::cell_ctrl_type ctl_c;
   logic                   full;
   logic                   has_item;
   logic [POS_W:0]         pos_ext;

   assign full     = (occ_ff == OCC_FULL);
   assign pos_ext  = {1'b0, pos_ff};
   assign has_item = (OCC_W'(pos_ext) < occ_ff);

   // Decode the operation into new count, cursor, error and a cell command
   always_comb begin
      occ_in = occ_ff;
      pos_in = pos_ff;
      err_in = cst_pkg::ERR_NONE;
      ctl_c  = '0;
      case (cst_pkg::mode_type'(mode))
         cst_pkg::MODE_START: begin
            pos_in = '0;
         end
         cst_pkg::MODE_END: begin
            pos_in = (occ_ff == '0) ? '0 : POS_W'(occ_ff - OCC_W'(1));
         end
         cst_pkg::MODE_LAST: begin
            pos_in = POS_LAST;
         end
         cst_pkg::MODE_ADVANCE: begin
            if (pos_ff != POS_LAST) pos_in = pos_ff + POS_W'(1);
         end
         cst_pkg::MODE_RETREAT: begin
            if (pos_ff != '0) pos_in = pos_ff - POS_W'(1);
         end
         cst_pkg::MODE_INSERT: begin
            if (full) begin
               err_in = cst_pkg::ERR_FULL;
            end else begin
               ctl_c.shift_up = 1'b1;
               ctl_c.write    = 1'b1;
               occ_in         = occ_ff + OCC_W'(1);
               if (has_item) begin
                  ctl_c.at = cst_pkg::IDX_W'(pos_ff);
               end else begin
                  ctl_c.at = '0;
                  pos_in   = '0;
               end
            end
         end
         cst_pkg::MODE_INSERT_FRONT: begin
            if (full) begin
               err_in = cst_pkg::ERR_FULL;
            end else begin
               ctl_c.shift_up = 1'b1;
               ctl_c.write    = 1'b1;
               ctl_c.at       = '0;
               occ_in         = occ_ff + OCC_W'(1);
               pos_in         = '0;
            end
         end
         cst_pkg::MODE_ATTACH: begin
            if (full) begin
               err_in = cst_pkg::ERR_FULL;
            end else begin
               ctl_c.shift_up = 1'b1;
               ctl_c.write    = 1'b1;
               occ_in         = occ_ff + OCC_W'(1);
               if (has_item) begin
                  ctl_c.at = cst_pkg::IDX_W'(pos_ext + (POS_W+1)'(1));
                  pos_in   = pos_ff + POS_W'(1);
               end else begin
                  ctl_c.at = cst_pkg::IDX_W'(occ_ff);
                  pos_in   = POS_W'(occ_ff);
               end
            end
         end
         cst_pkg::MODE_ATTACH_BACK: begin
            if (full) begin
               err_in = cst_pkg::ERR_FULL;
            end else begin
               ctl_c.shift_up = 1'b1;
               ctl_c.write    = 1'b1;
               ctl_c.at       = cst_pkg::IDX_W'(occ_ff);
               occ_in         = occ_ff + OCC_W'(1);
               pos_in         = POS_W'(occ_ff);
            end
         end
         cst_pkg::MODE_REMOVE_CURRENT: begin
            if (has_item) begin
               ctl_c.shift_down = 1'b1;
               ctl_c.at         = cst_pkg::IDX_W'(pos_ff);
               occ_in           = occ_ff - OCC_W'(1);
            end else begin
               err_in = cst_pkg::ERR_NO_ITEM;
            end
         end
         cst_pkg::MODE_REMOVE_FRONT: begin
            if (occ_ff != '0) begin
               ctl_c.shift_down = 1'b1;
               ctl_c.at         = '0;
               occ_in           = occ_ff - OCC_W'(1);
            end else begin
               err_in = cst_pkg::ERR_NO_ITEM;
            end
         end
         default: begin
            // read and unused codes: no change
         end
      endcase
   end

   // Command the row only on a transfer
   assign ctl = accept ? ctl_c : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         pos_ff <= '0;
      end else if (accept) begin
         occ_ff <= occ_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) err_ff <= err_in;
   end

   assign occ = occ_ff;
   assign pos = pos_ff;
   assign err = err_ff;

endmodule

`default_nettype wire

>>> sv/cursor_sequence_table_top.sv
`default_nettype none

// Channel  Dir  Handshake          Payload
// req_if   in   valid/ready        mode, value
// rsp_if   out  valid/ready        current_value, current_valid, count, cursor, error
//
// Each operation first updates the cell row, count and cursor at the transfer;
// the read stage then loads the cell at the cursor into the output register.
// Reset (synchronous, active high) empties the list and puts the cursor at 0.
// A new request is taken while an earlier response waits in the output register;
// the read stage holds until that register drains.

module cursor_sequence_table_top #(
   parameter int CAPACITY_ENTRIES = 32,
   parameter int WORD_WIDTH       = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   cst_req_if.sink   req_if,
   cst_rsp_if.source rsp_if
);

   localparam int OCC_W = $clog2(CAPACITY_ENTRIES + 1);
   localparam int POS_W = $clog2(CAPACITY_ENTRIES);

   cst_pkg::state_type     state_ff, state_in;
   cst_pkg::cell_ctrl_type ctl;
   cst_pkg::err_type       err;
   logic [OCC_W-1:0]       occ;
   logic [POS_W-1:0]       pos;
   logic                   accept;
   logic                   out_free;
   logic                   load_out;
   logic [63:0]            value_wide;
   logic [WORD_WIDTH-1:0]  word;
   logic [WORD_WIDTH-1:0]  entry [CAPACITY_ENTRIES];
   logic [63:0]            read_wide;
   logic                   item_here;
   logic [15:0]            occ_wide;
   logic [15:0]            pos_wide;

   logic                             rsp_valid_ff;
   logic [cst_pkg::VALUE_W-1:0]      cur_value_ff;
   logic                             cur_valid_ff;
   logic [cst_pkg::COUNT_W-1:0]      count_ff;
   logic [cst_pkg::CURSOR_W-1:0]     cursor_ff;
   cst_pkg::err_type                 err_out_ff;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Fit the request word to the stored width
   assign value_wide = 64'(req_if.value);
   assign word       = value_wide[WORD_WIDTH-1:0];

   cst_ctrl #(
      .CAPACITY_ENTRIES(CAPACITY_ENTRIES)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .mode  (req_if.mode),
      .ctl   (ctl),
      .occ   (occ),
      .pos   (pos),
      .err   (err)
   );

   // Row of cells, each handing its word to both neighbors
   for (genvar i = 0; i < CAPACITY_ENTRIES; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word;
      logic [WORD_WIDTH-1:0] right_word;
      if (i == 0) begin : g_first
         assign left_word = word;
      end else begin : g_mid_l
         assign left_word = entry[i-1];
      end
      if (i == CAPACITY_ENTRIES - 1) begin : g_end
         assign right_word = entry[i];
      end else begin : g_mid_r
         assign right_word = entry[i+1];
      end
      cst_cell #(
         .INDEX     (i),
         .WORD_WIDTH(WORD_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .word      (word),
         .left_word (left_word),
         .right_word(right_word),
         .entry     (entry[i])
      );
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cst_pkg::ST_IDLE: if (accept) state_in = cst_pkg::ST_LOAD;
         cst_pkg::ST_LOAD: if (out_free) state_in = cst_pkg::ST_IDLE;
         default:          state_in = cst_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_if.ready = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         cst_pkg::ST_IDLE: req_if.ready = 1'b1;
         cst_pkg::ST_LOAD: load_out     = out_free;
         default:          req_if.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Read the cell under the cursor
   assign item_here = (OCC_W'({1'b0, pos}) < occ);
   assign read_wide = 64'(entry[pos]);
   assign occ_wide  = 16'(occ);
   assign pos_wide  = 16'(pos);

   // Output register: fill on load, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         cur_value_ff <= item_here ? read_wide[cst_pkg::VALUE_W-1:0] : '0;
         cur_valid_ff <= item_here;
         count_ff     <= occ_wide[cst_pkg::COUNT_W-1:0];
         cursor_ff    <= pos_wide[cst_pkg::CURSOR_W-1:0];
         err_out_ff   <= err;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.current_value = cur_value_ff;
   assign rsp_if.current_valid = cur_valid_ff;
   assign rsp_if.count         = count_ff;
   assign rsp_if.cursor        = cursor_ff;
   assign rsp_if.error         = err_out_ff;

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ <= OCC_W'(CAPACITY_ENTRIES))
      else $error("entry count above capacity");

   a_full_err: assert property (@(posedge clock) disable iff (reset)
      load_out && (err == cst_pkg::ERR_FULL) |-> occ == OCC_W'(CAPACITY_ENTRIES))
      else $error("full error with room left");

   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      accept && (req_if.mode == cst_pkg::MODE_REMOVE_FRONT) && (occ == '0)
      |=> (err == cst_pkg::ERR_NO_ITEM) && (occ == '0))
      else $error("remove on empty list not rejected");

   a_valid_cursor: assert property (@(posedge clock) disable iff (reset)
      load_out && item_here |=> cur_valid_ff && (cursor_ff < count_ff || OCC_W > 6))
      else $error("valid item with cursor past count");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_if.ready)
      else $error("second request taken during read stage");
`endif

endmodule

`default_nettype wire
